@@ hw/rtl/hvt_pkg.sv @@
`default_nettype none

package hvt_pkg;

    typedef logic [2:0] req_t;

    localparam req_t REQ_POLL     = 3'd0;
    localparam req_t REQ_CTRL_WR  = 3'd1;
    localparam req_t REQ_NMI_READ = 3'd2;
    localparam req_t REQ_IRQ_READ = 3'd3;
    localparam req_t REQ_NMI_TEST = 3'd4;
    localparam req_t REQ_IRQ_TEST = 3'd5;

    localparam int CTRL_HEN_BIT   = 4;
    localparam int CTRL_VEN_BIT   = 5;
    localparam int CTRL_NMIEN_BIT = 7;

    localparam logic [10:0] IRQ_DELAY = 11'd10;
    localparam logic [10:0] NMI_DELAY = 11'd2;

    localparam logic [8:0] MATCH_RESET = 9'h1FF;

    localparam logic ADDR_H_MATCH = 1'b0;
    localparam logic ADDR_V_MATCH = 1'b1;

    typedef struct packed {
        logic [7:0]  write_data;
        logic [10:0] line_period;
        logic [8:0]  vblank_line;
        logic [8:0]  v_count;
        logic [10:0] h_count;
    } in_fields_t;

endpackage

`default_nettype wire

@@ hw/rtl/hv_timer_nmi_irq_controller_unit.sv @@
`default_nettype none

// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser req_type, tdata beam/control fields
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata result_flag, nmi_flag, irq_flag
// apb       in   psel/penable/pwrite/pready   h_match_raw @0x0, v_match @0x4
//
// One beat per cycle while the result is not held: state updates at the accepting
// edge, and the result beat is registered and shows up in the cycle after.
// A new beat is taken while the result register is empty or being drained.
// aresetn is synchronous: clears all flags, match registers return to 0x1FF.
// A stalled result holds; the input side stalls only while it is held.

module hv_timer_nmi_irq_controller_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,  // h_count, v_count, vblank_line,
                                            // line_period, write_data, irq_unmasked
    input  wire logic [2:0]  s_axis_tuser,  // req_type
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // result_flag, nmi_flag, irq_flag
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [8:0] h_match_raw_reg;
    logic [8:0] v_match_reg;

    logic nmi_enabled_reg, nmi_line_reg, nmi_cond_reg, nmi_hold_reg, nmi_pending_reg;
    logic h_irq_enabled_reg, v_irq_enabled_reg;
    logic irq_line_reg, irq_cond_reg, irq_hold_reg, irq_pending_reg;

    logic nmi_enabled_next, nmi_line_next, nmi_cond_next, nmi_hold_next, nmi_pending_next;
    logic h_irq_enabled_next, v_irq_enabled_next;
    logic irq_line_next, irq_cond_next, irq_hold_next, irq_pending_next;

    logic       out_valid_reg;
    logic [2:0] out_data_reg;
    logic       result_next;

    logic             in_accept;
    hvt_pkg::req_t    req;
    hvt_pkg::in_fields_t fld;
    logic             irq_unmasked;

    logic [8:0]  nmi_vd;
    logic        nmi_now;
    logic        irq_en;
    logic [11:0] h_sum;
    logic [11:0] irq_hd;
    logic        irq_h_oor;
    logic [8:0]  irq_vd;
    logic [11:0] h_target;
    logic        irq_active;
    logic        wr_hen, wr_ven, wr_en_any;
    logic        cfg_write;

    assign req          = s_axis_tuser;
    assign fld          = s_axis_tdata[47:0];
    assign irq_unmasked = s_axis_tdata[48];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_data_reg};

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        prdata = 32'd0;
        case (paddr[2])
            hvt_pkg::ADDR_H_MATCH: prdata = {23'd0, h_match_raw_reg};
            hvt_pkg::ADDR_V_MATCH: prdata = {23'd0, v_match_reg};
            default:               prdata = 32'd0;
        endcase
    end

    // beam position comparisons
    always_comb begin
        nmi_vd = (fld.h_count >= hvt_pkg::NMI_DELAY) ? fld.v_count :
                 ((fld.v_count != 9'd0) ? fld.v_count - 9'd1 : 9'd0);
        nmi_now = nmi_vd >= fld.vblank_line;

        irq_en   = h_irq_enabled_reg || v_irq_enabled_reg;
        h_sum    = {1'b0, fld.h_count} + {1'b0, fld.line_period};
        h_target = {({1'b0, h_match_raw_reg} + 10'd1), 2'b00};
        irq_h_oor = 1'b0;
        if (fld.h_count >= hvt_pkg::IRQ_DELAY) begin
            irq_hd = {1'b0, fld.h_count - hvt_pkg::IRQ_DELAY};
            irq_vd = fld.v_count;
        end else begin
            irq_h_oor = h_sum < {1'b0, hvt_pkg::IRQ_DELAY};
            irq_hd    = h_sum - {1'b0, hvt_pkg::IRQ_DELAY};
            irq_vd    = (fld.v_count != 9'd0) ? fld.v_count - 9'd1 : 9'd0;
        end
        irq_active = irq_en
            && (!v_irq_enabled_reg || irq_vd == v_match_reg)
            && (!h_irq_enabled_reg || (!irq_h_oor && irq_hd == h_target))
            && (irq_vd != 9'd0 || irq_h_oor || irq_hd != 12'd0);
    end

    assign wr_hen    = fld.write_data[hvt_pkg::CTRL_HEN_BIT];
    assign wr_ven    = fld.write_data[hvt_pkg::CTRL_VEN_BIT];
    assign wr_en_any = wr_hen || wr_ven;

    always_comb begin
        nmi_enabled_next   = nmi_enabled_reg;
        nmi_line_next      = nmi_line_reg;
        nmi_cond_next      = nmi_cond_reg;
        nmi_hold_next      = nmi_hold_reg;
        nmi_pending_next   = nmi_pending_reg;
        h_irq_enabled_next = h_irq_enabled_reg;
        v_irq_enabled_next = v_irq_enabled_reg;
        irq_line_next      = irq_line_reg;
        irq_cond_next      = irq_cond_reg;
        irq_hold_next      = irq_hold_reg;
        irq_pending_next   = irq_pending_reg;
        result_next        = 1'b0;

        case (req)
            hvt_pkg::REQ_POLL: begin
                if (nmi_hold_reg) begin
                    nmi_hold_next = 1'b0;
                    if (nmi_enabled_reg) begin
                        nmi_pending_next = 1'b1;
                    end
                end
                if (nmi_now != nmi_cond_reg) begin
                    nmi_cond_next = nmi_now;
                    nmi_line_next = nmi_now;
                    if (nmi_now) begin
                        nmi_hold_next = 1'b1;
                    end
                end

                irq_hold_next = 1'b0;
                if (irq_line_reg && irq_en) begin
                    irq_pending_next = 1'b1;
                end
                if (irq_active && !irq_cond_reg) begin
                    irq_cond_next = 1'b1;
                    irq_line_next = 1'b1;
                    irq_hold_next = 1'b1;
                end
                if (!irq_active && irq_cond_reg) begin
                    irq_cond_next = 1'b0;
                end
            end
            hvt_pkg::REQ_CTRL_WR: begin
                h_irq_enabled_next = wr_hen;
                v_irq_enabled_next = wr_ven;
                nmi_enabled_next   = fld.write_data[hvt_pkg::CTRL_NMIEN_BIT];
                if (!nmi_enabled_reg && nmi_enabled_next && nmi_line_reg) begin
                    nmi_pending_next = 1'b1;
                end
                if (wr_ven && !wr_hen && irq_line_reg) begin
                    irq_pending_next = 1'b1;
                end else if (!wr_en_any) begin
                    irq_line_next    = 1'b0;
                    irq_pending_next = 1'b0;
                end
            end
            hvt_pkg::REQ_NMI_READ: begin
                result_next = nmi_line_reg;
                if (!nmi_hold_reg) begin
                    nmi_line_next = 1'b0;
                end
            end
            hvt_pkg::REQ_IRQ_READ: begin
                result_next = irq_line_reg;
                if (!irq_hold_reg) begin
                    irq_line_next    = 1'b0;
                    irq_pending_next = 1'b0;
                end
            end
            hvt_pkg::REQ_NMI_TEST: begin
                result_next      = nmi_pending_reg;
                nmi_pending_next = 1'b0;
            end
            hvt_pkg::REQ_IRQ_TEST: begin
                if (irq_pending_reg) begin
                    irq_pending_next = 1'b0;
                    result_next      = irq_unmasked;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_match_raw_reg <= hvt_pkg::MATCH_RESET;
            v_match_reg     <= hvt_pkg::MATCH_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                hvt_pkg::ADDR_H_MATCH: h_match_raw_reg <= pwdata[8:0];
                hvt_pkg::ADDR_V_MATCH: v_match_reg     <= pwdata[8:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nmi_enabled_reg   <= 1'b0;
            nmi_line_reg      <= 1'b0;
            nmi_cond_reg      <= 1'b0;
            nmi_hold_reg      <= 1'b0;
            nmi_pending_reg   <= 1'b0;
            h_irq_enabled_reg <= 1'b0;
            v_irq_enabled_reg <= 1'b0;
            irq_line_reg      <= 1'b0;
            irq_cond_reg      <= 1'b0;
            irq_hold_reg      <= 1'b0;
            irq_pending_reg   <= 1'b0;
        end else if (in_accept) begin
            nmi_enabled_reg   <= nmi_enabled_next;
            nmi_line_reg      <= nmi_line_next;
            nmi_cond_reg      <= nmi_cond_next;
            nmi_hold_reg      <= nmi_hold_next;
            nmi_pending_reg   <= nmi_pending_next;
            h_irq_enabled_reg <= h_irq_enabled_next;
            v_irq_enabled_reg <= v_irq_enabled_next;
            irq_line_reg      <= irq_line_next;
            irq_cond_reg      <= irq_cond_next;
            irq_hold_reg      <= irq_hold_next;
            irq_pending_reg   <= irq_pending_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            out_data_reg <= {irq_line_next, nmi_line_next, result_next};
        end
    end

`ifndef NO_ASSERTIONS
    a_accept_gives_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> m_axis_tvalid)
        else $error("accepted beat produced no result");

    a_irq_off_clears_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && req == hvt_pkg::REQ_CTRL_WR && !wr_hen && !wr_ven)
        |=> (!irq_line_reg && !irq_pending_reg && !m_axis_tdata[2]))
        else $error("IRQ line survived disabling write");

    a_nmi_hold_state: assert property (@(posedge aclk) disable iff (!aresetn)
        nmi_hold_reg |-> (nmi_line_reg && nmi_cond_reg))
        else $error("NMI hold without active line");

    a_irq_hold_state: assert property (@(posedge aclk) disable iff (!aresetn)
        irq_hold_reg |-> irq_cond_reg)
        else $error("IRQ hold without active condition");
`endif

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hvt_pkg::*;

    localparam req_t REQ_SPARE_LO = 3'd6;
    localparam req_t REQ_SPARE_HI = 3'd7;
    localparam int   H_NOWHERE    = 'hFFFF;
    localparam int   STALL_LIMIT  = 2000;
    localparam int   CALM_START   = 1500;
    localparam int   CALM_END     = 2300;

    typedef struct {
        req_t       kind;
        in_fields_t f;
        logic       unm;
    } hv_req_t;

    typedef struct packed {
        logic irq;
        logic nmi;
        logic flag;
    } flags_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [7:0]  m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    hv_timer_nmi_irq_controller_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // predictor state
    logic [8:0] h_match, v_match;
    bit nmi_en, nmi_line, nmi_cond, nmi_hold, nmi_pend;
    bit h_en, v_en, irq_line, irq_cond, irq_hold, irq_pend;

    hv_req_t req_q[$];
    flags_t  flags_q[$];
    int      queued_cnt = 0;
    int      taken_cnt = 0;
    int      err_cnt = 0;
    int      cyc = 0;
    int      stall_cnt = 0;
    bit      in_took = 1'b0;
    bit      calm = 1'b0;

    task automatic report_err(string msg);
        $display("tb_top: mismatch @%0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    function automatic flags_t hvt_predict(req_t kind, in_fields_t f, logic unm);
        flags_t o;
        int     h, v, hd, vd, vdn, sum;
        bit     now, en, active;
        o = '0;
        h = int'(f.h_count);
        v = int'(f.v_count);
        case (kind)
            REQ_POLL: begin
                if (nmi_hold) begin
                    nmi_hold = 1'b0;
                    if (nmi_en) nmi_pend = 1'b1;
                end
                vdn = (h >= int'(NMI_DELAY)) ? v : (v > 0 ? v - 1 : 0);
                now = vdn >= int'(f.vblank_line);
                if (now != nmi_cond) begin
                    nmi_cond = now;
                    nmi_line = now;
                    if (now) nmi_hold = 1'b1;
                end
                en = h_en || v_en;
                irq_hold = 1'b0;
                if (irq_line && en) irq_pend = 1'b1;
                if (h >= int'(IRQ_DELAY)) begin
                    hd = h - int'(IRQ_DELAY);
                    vd = v;
                end else begin
                    sum = h + int'(f.line_period);
                    hd = (sum >= int'(IRQ_DELAY)) ? sum - int'(IRQ_DELAY) : H_NOWHERE;
                    vd = v > 0 ? v - 1 : 0;
                end
                // first dot of the frame (delayed position 0,0) never fires
                active = en && (!v_en || vd == int'(v_match))
                    && (!h_en || hd == (int'(h_match) + 1) * 4)
                    && (vd > 0 || hd > 0);
                if (active && !irq_cond) begin
                    irq_cond = 1'b1;
                    irq_line = 1'b1;
                    irq_hold = 1'b1;
                end
                if (!active && irq_cond) irq_cond = 1'b0;
            end
            REQ_CTRL_WR: begin
                now = nmi_en;
                h_en   = f.write_data[CTRL_HEN_BIT];
                v_en   = f.write_data[CTRL_VEN_BIT];
                nmi_en = f.write_data[CTRL_NMIEN_BIT];
                if (!now && nmi_en && nmi_line) nmi_pend = 1'b1;
                if (v_en && !h_en && irq_line) begin
                    irq_pend = 1'b1;
                end else if (!h_en && !v_en) begin
                    irq_line = 1'b0;
                    irq_pend = 1'b0;
                end
            end
            REQ_NMI_READ: begin
                o.flag = nmi_line;
                if (!nmi_hold) nmi_line = 1'b0;
            end
            REQ_IRQ_READ: begin
                o.flag = irq_line;
                if (!irq_hold) begin
                    irq_line = 1'b0;
                    irq_pend = 1'b0;
                end
            end
            REQ_NMI_TEST: begin
                o.flag = nmi_pend;
                nmi_pend = 1'b0;
            end
            REQ_IRQ_TEST: begin
                if (irq_pend) begin
                    irq_pend = 1'b0;
                    o.flag = unm;
                end
            end
            default: ;
        endcase
        o.nmi = nmi_line;
        o.irq = irq_line;
        return o;
    endfunction

    // driver: one beat per handshake, random gaps outside the calm window
    hv_req_t drv_item;
    bit      drv_go;

    always @(negedge aclk) begin
        if (!s_axis_tvalid || in_took) begin
            drv_go = req_q.size() != 0 && (calm || $urandom_range(0, 99) >= 11);
            if (drv_go) begin
                drv_item = req_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {7'd0, drv_item.unm, drv_item.f};
                s_axis_tuser  <= drv_item.kind;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 11);
    end

    // monitor, predictor and watchdog
    flags_t     got, want;
    in_fields_t mon_f;
    bit         out_took, cfg_took;

    always @(posedge aclk) begin
        if (!aresetn) begin
            h_match  = MATCH_RESET;
            v_match  = MATCH_RESET;
            nmi_en   = 1'b0; nmi_line = 1'b0; nmi_cond = 1'b0;
            nmi_hold = 1'b0; nmi_pend = 1'b0;
            h_en     = 1'b0; v_en     = 1'b0; irq_line = 1'b0;
            irq_cond = 1'b0; irq_hold = 1'b0; irq_pend = 1'b0;
            in_took  = 1'b0;
        end else begin
            cyc++;
            calm = cyc >= CALM_START && cyc < CALM_END;
            in_took  = s_axis_tvalid && s_axis_tready;
            out_took = m_axis_tvalid && m_axis_tready;
            cfg_took = psel && penable && pwrite && pready;
            if (out_took) begin
                got = m_axis_tdata[2:0];
                if (flags_q.size() == 0) begin
                    report_err("result beat with nothing expected");
                end else begin
                    want = flags_q.pop_front();
                    if (got.flag !== want.flag)
                        report_err($sformatf("result_flag %b, want %b", got.flag, want.flag));
                    if (got.nmi !== want.nmi)
                        report_err($sformatf("nmi_flag %b, want %b", got.nmi, want.nmi));
                    if (got.irq !== want.irq)
                        report_err($sformatf("irq_flag %b, want %b", got.irq, want.irq));
                end
            end
            if (in_took) begin
                mon_f = s_axis_tdata[47:0];
                flags_q.push_back(hvt_predict(req_t'(s_axis_tuser), mon_f, s_axis_tdata[48]));
                taken_cnt++;
            end
            if (cfg_took) begin
                if (paddr[2] == ADDR_V_MATCH) v_match = pwdata[8:0];
                else h_match = pwdata[8:0];
            end
            if (in_took || out_took || cfg_took) stall_cnt = 0;
            else stall_cnt++;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    task automatic send_req(req_t kind, int h, int v, int vb, int lp, int wd, logic unm);
        hv_req_t it;
        it.kind = kind;
        it.f.h_count = 11'(h);
        it.f.v_count = 9'(v);
        it.f.vblank_line = 9'(vb);
        it.f.line_period = 11'(lp);
        it.f.write_data = 8'(wd);
        it.unm = unm;
        req_q.push_back(it);
        queued_cnt++;
    endtask

    task automatic drain();
        while (taken_cnt != queued_cnt || flags_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic apb_write(logic sel, logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // beam sweeps through small frames, CPU accesses interleaved, some noise
    task automatic beam_phase(int lp, int lines, int n);
        int h, v, vb, i, r;
        vb = $urandom_range(2, lines - 1);
        h  = $urandom_range(0, lp - 1);
        v  = $urandom_range(0, lines - 1);
        for (i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                send_req(req_t'($urandom_range(0, 7)), $urandom_range(0, 2047),
                    $urandom_range(0, 511), $urandom_range(0, 511),
                    $urandom_range(0, 2047), $urandom_range(0, 255), $urandom_range(0, 1));
            end else if (r < 60) begin
                h += $urandom_range(1, 3);
                if (h >= lp) begin
                    h -= lp;
                    v = (v + 1) % lines;
                end
                send_req(REQ_POLL, h, v, vb, lp, $urandom_range(0, 255),
                    $urandom_range(0, 1));
            end else begin
                send_req(req_t'($urandom_range(REQ_CTRL_WR, REQ_IRQ_TEST)),
                    $urandom_range(0, 2047), $urandom_range(0, 511),
                    $urandom_range(0, 511), $urandom_range(0, 2047),
                    $urandom_range(0, 255), $urandom_range(0, 1));
            end
        end
    endtask

    int ph, lp, lines, hm, vm;

    initial begin
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        // reset targets, all enables, edges and clamps
        send_req(REQ_SPARE_LO, 2047, 511, 511, 2047, 255, 1'b1);
        send_req(REQ_SPARE_HI, 0, 0, 0, 0, 0, 1'b0);
        send_req(REQ_CTRL_WR, 0, 0, 0, 0, 'hB0, 1'b0);
        send_req(REQ_POLL, 0, 0, 0, 0, 0, 1'b0);
        send_req(REQ_POLL, 1, 0, 0, 5, 0, 1'b0);
        send_req(REQ_NMI_READ, 0, 0, 0, 0, 0, 1'b0);
        send_req(REQ_NMI_TEST, 0, 0, 0, 0, 0, 1'b0);
        send_req(REQ_POLL, 2047, 511, 511, 2047, 0, 1'b0);
        send_req(REQ_IRQ_READ, 0, 0, 0, 0, 0, 1'b0);
        send_req(REQ_CTRL_WR, 0, 0, 0, 0, 'h20, 1'b0);
        send_req(REQ_IRQ_TEST, 0, 0, 0, 0, 0, 1'b1);
        send_req(REQ_IRQ_TEST, 0, 0, 0, 0, 0, 1'b0);
        send_req(REQ_CTRL_WR, 0, 0, 0, 0, 'h00, 1'b0);
        send_req(REQ_CTRL_WR, 0, 0, 0, 0, 'hFF, 1'b1);
        send_req(REQ_POLL, 9, 1, 1, 2047, 'hFF, 1'b1);
        drain();

        // lowest targets: H match directly, at line wrap, and the frame-start guard
        apb_write(ADDR_H_MATCH, 32'd0);
        apb_write(ADDR_V_MATCH, 32'd0);
        send_req(REQ_CTRL_WR, 0, 0, 0, 0, 'h30, 1'b0);
        send_req(REQ_POLL, 14, 0, 8, 40, 0, 1'b0);
        send_req(REQ_IRQ_READ, 0, 0, 0, 0, 0, 1'b0);
        send_req(REQ_POLL, 10, 0, 8, 40, 0, 1'b0);
        send_req(REQ_CTRL_WR, 0, 0, 0, 0, 'h10, 1'b0);
        send_req(REQ_POLL, 3, 1, 8, 11, 0, 1'b0);
        send_req(REQ_IRQ_TEST, 0, 0, 0, 0, 0, 1'b1);
        beam_phase(40, 6, 240);
        drain();

        for (ph = 0; ph < 5; ph++) begin
            lp    = $urandom_range(24, 64);
            lines = $urandom_range(5, 10);
            case (ph)
                2: begin
                    hm = ($urandom & 32'hFFFF_FE00) | 511;
                    vm = ($urandom & 32'hFFFF_FE00) | 511;
                end
                3: begin
                    hm = 0;
                    vm = lines - 1;
                end
                default: begin
                    hm = $urandom_range(0, (lp - 14) / 4);
                    vm = $urandom_range(0, lines - 1);
                end
            endcase
            apb_write(ADDR_H_MATCH, hm);
            apb_write(ADDR_V_MATCH, vm);
            beam_phase(lp, lines, 240);
            drain();
        end

        repeat (10) @(negedge aclk);
        if (err_cnt == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
